### rtl/idalloc_pkg.sv
// Shared types, codes and defaults for the identifier allocator.
package idalloc_pkg;

   localparam int MAX_IDS_DEF = 256;

   localparam int CMD_W    = 3;
   localparam int REQ_ID_W = 8;
   localparam int GOT_ID_W = 8;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] STS_UNAVAIL   = 2'd2;
   localparam logic [STATUS_W-1:0] STS_RANGE     = 2'd3;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DECODE,
      ST_FILL,
      ST_SCAN,
      ST_SHIFT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [GOT_ID_W-1:0] got_id;
      logic [STATUS_W-1:0] status;
      logic                is_free;
   } res_type;

endpackage

### rtl/idalloc_if.sv
// Request and response channel interfaces of the identifier allocator.
interface idalloc_req_if;
   logic                              valid;
   logic                              ready;
   logic [idalloc_pkg::CMD_W-1:0]     cmd;
   logic [idalloc_pkg::REQ_ID_W-1:0]  req_id;

   modport source (output valid, output cmd, output req_id, input ready);
   modport sink (input valid, input cmd, input req_id, output ready);
endinterface

interface idalloc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [idalloc_pkg::GOT_ID_W-1:0]  got_id;
   logic [idalloc_pkg::STATUS_W-1:0]  status;
   logic                              is_free;

   modport source (output valid, output got_id, output status, output is_free, input ready);
   modport sink (input valid, input got_id, input status, input is_free, output ready);
endinterface

### rtl/idalloc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module idalloc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic                                rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/idalloc_core.sv
// Command sequencer: free list and taken bitmap kept in two RAMs, high-water mark in a register.
module idalloc_core #(
   parameter int MAX_IDS = idalloc_pkg::MAX_IDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   idalloc_req_if.sink          req_ch,
   input  logic                 slot_free,
   output logic                 res_valid,
   output idalloc_pkg::res_type res_word
);

   localparam int IdW  = $clog2(MAX_IDS);
   localparam int CntW = $clog2(MAX_IDS + 1);
   localparam int CmpW = (CntW > idalloc_pkg::REQ_ID_W) ? CntW : idalloc_pkg::REQ_ID_W;

   function automatic logic [IdW-1:0] inc_ptr(input logic [IdW-1:0] p);
      logic [IdW-1:0] r;
      if (p == IdW'(MAX_IDS - 1)) begin
         r = '0;
      end else begin
         r = p + IdW'(1);
      end
      return r;
   endfunction

   function automatic logic [IdW-1:0] dec_ptr(input logic [IdW-1:0] p);
      logic [IdW-1:0] r;
      if (p == '0) begin
         r = IdW'(MAX_IDS - 1);
      end else begin
         r = p - IdW'(1);
      end
      return r;
   endfunction

   idalloc_pkg::state_type state_ff, state_in;
   logic [idalloc_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [idalloc_pkg::REQ_ID_W-1:0] id_ff, id_in;
   logic                             taken_ff, taken_in;
   logic [IdW-1:0]                   head_ff, head_in;
   logic [IdW-1:0]                   tail_ff, tail_in;
   logic [CntW-1:0]                  count_ff, count_in;
   logic [CntW-1:0]                  mark_ff, mark_in;
   logic [IdW-1:0]                   ptr_a_ff, ptr_a_in;
   logic [IdW-1:0]                   ptr_b_ff, ptr_b_in;
   logic [CntW-1:0]                  idx_a_ff, idx_a_in;
   logic [CntW-1:0]                  idx_b_ff, idx_b_in;
   logic                             rvld_ff, rvld_in;
   logic [IdW-1:0]                   sweep_ff, sweep_in;
   logic                             pend_ff, pend_in;
   idalloc_pkg::res_type             res_ff, res_in;

   logic           fl_we, fl_re;
   logic [IdW-1:0] fl_waddr, fl_raddr, fl_wdata, fl_rdata;
   logic           tk_we, tk_re;
   logic [IdW-1:0] tk_waddr, tk_raddr;
   logic [0:0]     tk_wdata, tk_rdata;

   logic            accept;
   logic [CmpW-1:0] id_cmp, mark_cmp, max_cmp;
   logic [IdW-1:0]  id_addr;
   logic            in_range, above, list_empty, list_full, mark_full;
   logic            hit, scan_end, shift_end, sweep_end, fill_end;
   logic            is_ranged_cmd;

   idalloc_ram #(.WIDTH(IdW), .DEPTH(MAX_IDS)) u_free_ram (
      .clock   (clock),
      .wr_en   (fl_we),
      .wr_addr (fl_waddr),
      .wr_data (fl_wdata),
      .rd_en   (fl_re),
      .rd_addr (fl_raddr),
      .rd_data (fl_rdata)
   );

   idalloc_ram #(.WIDTH(1), .DEPTH(MAX_IDS)) u_taken_ram (
      .clock   (clock),
      .wr_en   (tk_we),
      .wr_addr (tk_waddr),
      .wr_data (tk_wdata),
      .rd_en   (tk_re),
      .rd_addr (tk_raddr),
      .rd_data (tk_rdata)
   );

   assign accept        = req_ch.valid && req_ch.ready;
   assign id_cmp        = CmpW'(id_ff);
   assign mark_cmp      = CmpW'(mark_ff);
   assign max_cmp       = CmpW'(MAX_IDS);
   assign id_addr       = IdW'(id_ff);
   assign in_range      = id_cmp < max_cmp;
   assign above         = id_cmp >= mark_cmp;
   assign list_empty    = count_ff == '0;
   assign list_full     = count_ff == CntW'(MAX_IDS);
   assign mark_full     = mark_ff == CntW'(MAX_IDS);
   assign hit           = rvld_ff && (fl_rdata == id_addr);
   assign scan_end      = !rvld_ff && (idx_a_ff == count_ff);
   assign shift_end     = !rvld_ff && (idx_a_ff == '0);
   assign sweep_end     = sweep_ff == IdW'(MAX_IDS - 1);
   assign fill_end      = !(mark_cmp < id_cmp);
   assign is_ranged_cmd = (cmd_ff == idalloc_pkg::CMD_RESERVE)
                       || (cmd_ff == idalloc_pkg::CMD_RELEASE)
                       || (cmd_ff == idalloc_pkg::CMD_QUERY);

   assign req_ch.ready = state_ff == idalloc_pkg::ST_IDLE;
   assign res_valid    = state_ff == idalloc_pkg::ST_RESP;
   assign res_word     = res_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         idalloc_pkg::ST_SWEEP: begin
            if (sweep_end) begin
               state_in = pend_ff ? idalloc_pkg::ST_RESP : idalloc_pkg::ST_IDLE;
            end
         end
         idalloc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = idalloc_pkg::ST_DECODE;
            end
         end
         idalloc_pkg::ST_DECODE: begin
            state_in = idalloc_pkg::ST_RESP;
            if (is_ranged_cmd && !in_range) begin
               state_in = idalloc_pkg::ST_RESP;
            end else if (cmd_ff == idalloc_pkg::CMD_RESERVE) begin
               if (above) begin
                  state_in = idalloc_pkg::ST_FILL;
               end else if (!list_empty) begin
                  state_in = idalloc_pkg::ST_SCAN;
               end
            end else if (cmd_ff == idalloc_pkg::CMD_QUERY) begin
               if (!above && !list_empty) begin
                  state_in = idalloc_pkg::ST_SCAN;
               end
            end else if (cmd_ff == idalloc_pkg::CMD_CLEAR) begin
               state_in = idalloc_pkg::ST_SWEEP;
            end
         end
         idalloc_pkg::ST_FILL: begin
            if (fill_end) begin
               state_in = idalloc_pkg::ST_RESP;
            end
         end
         idalloc_pkg::ST_SCAN: begin
            if (hit) begin
               if (cmd_ff == idalloc_pkg::CMD_RESERVE && idx_b_ff != '0) begin
                  state_in = idalloc_pkg::ST_SHIFT;
               end else begin
                  state_in = idalloc_pkg::ST_RESP;
               end
            end else if (scan_end) begin
               state_in = idalloc_pkg::ST_RESP;
            end
         end
         idalloc_pkg::ST_SHIFT: begin
            if (shift_end) begin
               state_in = idalloc_pkg::ST_RESP;
            end
         end
         idalloc_pkg::ST_RESP: begin
            if (slot_free) begin
               state_in = idalloc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = idalloc_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and memory accesses.
   always_comb begin
      cmd_in   = cmd_ff;
      id_in    = id_ff;
      taken_in = taken_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      mark_in  = mark_ff;
      ptr_a_in = ptr_a_ff;
      ptr_b_in = ptr_b_ff;
      idx_a_in = idx_a_ff;
      idx_b_in = idx_b_ff;
      rvld_in  = rvld_ff;
      sweep_in = sweep_ff;
      pend_in  = pend_ff;
      res_in   = res_ff;
      fl_we    = 1'b0;
      fl_waddr = tail_ff;
      fl_wdata = id_addr;
      fl_re    = 1'b0;
      fl_raddr = head_ff;
      tk_we    = 1'b0;
      tk_waddr = id_addr;
      tk_wdata = 1'b1;
      tk_re    = 1'b0;
      tk_raddr = IdW'(req_ch.req_id);

      case (state_ff)
         idalloc_pkg::ST_SWEEP: begin
            tk_we    = 1'b1;
            tk_waddr = sweep_ff;
            tk_wdata = 1'b0;
            sweep_in = inc_ptr(sweep_ff);
            if (sweep_end) begin
               pend_in = 1'b0;
            end
         end
         idalloc_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in = req_ch.cmd;
               id_in  = req_ch.req_id;
               res_in = '0;
               fl_re  = 1'b1;
               tk_re  = 1'b1;
            end
         end
         idalloc_pkg::ST_DECODE: begin
            taken_in = tk_rdata[0];
            ptr_a_in = head_ff;
            idx_a_in = '0;
            rvld_in  = 1'b0;
            if (is_ranged_cmd && !in_range) begin
               res_in.status = idalloc_pkg::STS_RANGE;
            end else begin
               case (cmd_ff)
                  idalloc_pkg::CMD_ALLOC: begin
                     if (!list_empty) begin
                        res_in.got_id = idalloc_pkg::GOT_ID_W'(fl_rdata);
                        head_in       = inc_ptr(head_ff);
                        count_in      = count_ff - CntW'(1);
                        tk_we         = 1'b1;
                        tk_waddr      = fl_rdata;
                     end else if (!mark_full) begin
                        res_in.got_id = idalloc_pkg::GOT_ID_W'(mark_ff);
                        mark_in       = mark_ff + CntW'(1);
                        tk_we         = 1'b1;
                        tk_waddr      = IdW'(mark_ff);
                     end else begin
                        res_in.status = idalloc_pkg::STS_EXHAUSTED;
                     end
                  end
                  idalloc_pkg::CMD_RESERVE: begin
                     if (!above && list_empty) begin
                        res_in.status = idalloc_pkg::STS_UNAVAIL;
                     end
                  end
                  idalloc_pkg::CMD_RELEASE: begin
                     if (tk_rdata[0]) begin
                        tk_we    = 1'b1;
                        tk_wdata = 1'b0;
                        if (!list_full) begin
                           fl_we    = 1'b1;
                           tail_in  = inc_ptr(tail_ff);
                           count_in = count_ff + CntW'(1);
                        end
                     end else begin
                        res_in.status = idalloc_pkg::STS_UNAVAIL;
                     end
                  end
                  idalloc_pkg::CMD_QUERY: begin
                     if (above) begin
                        res_in.is_free = 1'b1;
                     end
                  end
                  idalloc_pkg::CMD_CLEAR: begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                     mark_in  = '0;
                     sweep_in = '0;
                     pend_in  = 1'b1;
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end
         idalloc_pkg::ST_FILL: begin
            if (!fill_end) begin
               if (!list_full) begin
                  fl_we    = 1'b1;
                  fl_wdata = IdW'(mark_ff);
                  tail_in  = inc_ptr(tail_ff);
                  count_in = count_ff + CntW'(1);
               end
               mark_in = mark_ff + CntW'(1);
            end else begin
               mark_in       = CntW'(id_cmp + CmpW'(1));
               tk_we         = 1'b1;
               res_in.got_id = id_ff;
            end
         end
         idalloc_pkg::ST_SCAN: begin
            if (idx_a_ff < count_ff) begin
               fl_re    = 1'b1;
               fl_raddr = ptr_a_ff;
               ptr_a_in = inc_ptr(ptr_a_ff);
               idx_a_in = idx_a_ff + CntW'(1);
               ptr_b_in = ptr_a_ff;
               idx_b_in = idx_a_ff;
               rvld_in  = 1'b1;
            end else begin
               rvld_in = 1'b0;
            end
            if (hit) begin
               rvld_in  = 1'b0;
               ptr_b_in = ptr_b_ff;
               idx_b_in = idx_b_ff;
               if (cmd_ff == idalloc_pkg::CMD_QUERY) begin
                  res_in.is_free = !taken_ff;
               end else begin
                  res_in.got_id = id_ff;
                  tk_we         = 1'b1;
                  if (idx_b_ff == '0) begin
                     head_in  = inc_ptr(head_ff);
                     count_in = count_ff - CntW'(1);
                  end else begin
                     ptr_a_in = inc_ptr(ptr_b_ff);
                     idx_a_in = count_ff - idx_b_ff - CntW'(1);
                  end
               end
            end else if (scan_end && cmd_ff == idalloc_pkg::CMD_RESERVE) begin
               res_in.status = idalloc_pkg::STS_UNAVAIL;
            end
         end
         idalloc_pkg::ST_SHIFT: begin
            if (idx_a_ff != '0) begin
               fl_re    = 1'b1;
               fl_raddr = ptr_a_ff;
               ptr_a_in = inc_ptr(ptr_a_ff);
               idx_a_in = idx_a_ff - CntW'(1);
               rvld_in  = 1'b1;
            end else begin
               rvld_in = 1'b0;
            end
            if (rvld_ff) begin
               fl_we    = 1'b1;
               fl_waddr = ptr_b_ff;
               fl_wdata = fl_rdata;
               ptr_b_in = inc_ptr(ptr_b_ff);
            end
            if (shift_end) begin
               count_in = count_ff - CntW'(1);
               tail_in  = dec_ptr(tail_ff);
            end
         end
         idalloc_pkg::ST_RESP: begin
            res_in = res_ff;
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idalloc_pkg::ST_SWEEP;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         mark_ff  <= '0;
         rvld_ff  <= 1'b0;
         sweep_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         mark_ff  <= mark_in;
         rvld_ff  <= rvld_in;
         sweep_ff <= sweep_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      id_ff    <= id_in;
      taken_ff <= taken_in;
      ptr_a_ff <= ptr_a_in;
      ptr_b_ff <= ptr_b_in;
      idx_a_ff <= idx_a_in;
      idx_b_ff <= idx_b_in;
      res_ff   <= res_in;
   end

endmodule

### rtl/id_allocator_free_list_top.sv
// Top level of the identifier allocator with an ordered free list and a high-water mark.
//
// A request word carries a command (allocate, reserve, release, query, clear) and an
// identifier; every accepted request yields exactly one response word with the
// identifier handed out, a status code and the query answer.
// Both channels use valid/ready; a word moves on a clock edge where both are high.
// The free list and the taken bitmap each sit in a synchronous RAM of MAX_IDS entries.
// Reserve at or above the mark appends each skipped identifier to the list. Reserve or
// query below the mark walks the list one entry per cycle. A reserve that removes an
// entry other than the head then moves each later entry up one place, one per cycle.
// Clear rewrites the bitmap one entry per cycle. One request is in work at a time; a
// new request is taken as soon as the previous one has reached the response register,
// even while the receiver still stalls it. After reset the whole bitmap is swept with
// req_ch.ready low; the list is empty and the mark is zero. A stalled response holds
// its word until taken.
module id_allocator_free_list_top #(
   parameter int MAX_IDS = idalloc_pkg::MAX_IDS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   idalloc_req_if.sink  req_ch,
   idalloc_rsp_if.source rsp_ch
);

   logic                 slot_free;
   logic                 res_valid;
   idalloc_pkg::res_type res_word;
   logic                 rsp_vld_ff, rsp_vld_in;
   idalloc_pkg::res_type rsp_ff, rsp_in;

   idalloc_core #(.MAX_IDS(MAX_IDS)) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .slot_free (slot_free),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   assign slot_free = !rsp_vld_ff || rsp_ch.ready;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      if (res_valid && slot_free) begin
         rsp_vld_in = 1'b1;
         rsp_in     = res_word;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid   = rsp_vld_ff;
   assign rsp_ch.got_id  = rsp_ff.got_id;
   assign rsp_ch.status  = rsp_ff.status;
   assign rsp_ch.is_free = rsp_ff.is_free;

endmodule
